FILE: sv/ipr_pkg.sv
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared types and constants for the integer pixel replication scaler.
// ----------------------------------------------------------------------------
package ipr_pkg;

    // line buffer geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // field and register widths
    localparam int PIX_W     = 24;
    localparam int SCALE_W   = 7;
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int PAD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // clamp for the enlargement factor
    localparam int SCALE_LIMIT = 100;

    // command codes
    typedef enum logic
    {
        CMD_PUSH   = 1'b0,
        CMD_REPLAY = 1'b1
    } cmd_t;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_SCALE    = 2'd0,
        REG_IN_WIDTH = 2'd1,
        REG_IN_HEIGHT = 2'd2
    } reg_idx_t;

endpackage

FILE: sv/ipr_ram.sv
// ----------------------------------------------------------------------------
// ipr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ipr_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port, read data holds when idle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/integer_pixel_replication_scaler.sv
// ----------------------------------------------------------------------------
// integer_pixel_replication_scaler
// Nearest-neighbor integer upscaler: pushes store pixels in a line buffer,
// replays read them back for the vertical copies of each row.
// ----------------------------------------------------------------------------
// The output is registered: an accepted item appears in the next cycle.
// Throughput: one item per cycle when not stalled; one buffer access per item.
// The output register is released in the same cycle it is taken, so a new
// item is accepted while a result waits only when that result leaves.
// Reset clears the counters and output valid and loads scale, in_width and
// in_height with 1; the line buffer has no reset and is read only after write.
module integer_pixel_replication_scaler
    import ipr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [PIX_W-1:0]     pixel,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     out_pixel,
    output logic [SCALE_W-1:0]   repeat_res,
    output logic [PAD_W-1:0]     pad_bytes,
    output logic                 row_end,
    output logic                 image_end,
    output logic                 phase_error
);

    // configuration registers
    logic [SCALE_W-1:0]  scale_reg;
    logic [WIDTH_W-1:0]  in_width_reg;
    logic [HEIGHT_W-1:0] in_height_reg;

    // position counters
    logic [COL_W-1:0]    column_reg,     column_next;
    logic [SCALE_W-1:0]  row_copy_reg,   row_copy_next;
    logic [HEIGHT_W-1:0] source_row_reg, source_row_next;

    // output register
    logic                out_valid_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic                use_ram_reg;
    logic [SCALE_W-1:0]  repeat_reg;
    logic [PAD_W-1:0]    pad_reg;
    logic                row_end_reg;
    logic                image_end_reg;
    logic                err_reg;

    logic [SCALE_W-1:0]  eff_scale;
    logic [WIDTH_W-1:0]  eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    logic [WIDTH_W-1:0]  col_inc;
    logic [SCALE_W:0]    copy_inc;
    logic [HEIGHT_W:0]   srow_inc;
    logic                accept;
    logic                bad_phase;
    logic                rend;
    logic                iend;
    logic                ram_we;
    logic                ram_re;
    logic [PIX_W-1:0]    ram_rdata;
    logic [PAD_W-1:0]    pad_calc;

    // handshake
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // effective register values after clamping
    always_comb
    begin
        if (scale_reg == '0)
            eff_scale = SCALE_W'(1);
        else if (scale_reg > SCALE_W'(SCALE_LIMIT))
            eff_scale = SCALE_W'(SCALE_LIMIT);
        else
            eff_scale = scale_reg;

        if (in_width_reg == '0)
            eff_width = WIDTH_W'(1);
        else if (in_width_reg > WIDTH_W'(MAX_WIDTH))
            eff_width = WIDTH_W'(MAX_WIDTH);
        else
            eff_width = in_width_reg;

        eff_height = (in_height_reg == '0) ? HEIGHT_W'(1) : in_height_reg;
    end

    // phase check and counter advance
    always_comb
    begin
        bad_phase = (command == CMD_PUSH) ? (row_copy_reg != '0) : (row_copy_reg == '0);
        col_inc   = WIDTH_W'(column_reg) + WIDTH_W'(1);
        copy_inc  = {1'b0, row_copy_reg} + (SCALE_W+1)'(1);
        srow_inc  = {1'b0, source_row_reg} + (HEIGHT_W+1)'(1);
        rend      = (col_inc >= eff_width);
        iend      = 1'b0;

        column_next     = column_reg;
        row_copy_next   = row_copy_reg;
        source_row_next = source_row_reg;

        if (rend)
        begin
            column_next = '0;
            if (copy_inc >= {1'b0, eff_scale})
            begin
                row_copy_next = '0;
                if (srow_inc >= {1'b0, eff_height})
                begin
                    source_row_next = '0;
                    iend            = 1'b1;
                end
                else
                begin
                    source_row_next = srow_inc[HEIGHT_W-1:0];
                end
            end
            else
            begin
                row_copy_next = copy_inc[SCALE_W-1:0];
            end
        end
        else
        begin
            column_next = col_inc[COL_W-1:0];
        end
    end

    // row padding: (width * scale) mod 4 from the low two bits of each
    always_comb
    begin
        logic [3:0] prod;
        prod     = 4'(eff_width[1:0] * eff_scale[1:0]);
        pad_calc = prod[PAD_W-1:0];
    end

    // line buffer: push writes the current column, replay reads it.
    // a replay of a column always follows its push
    assign ram_we = accept & ~bad_phase & (command == CMD_PUSH);
    assign ram_re = accept & ~bad_phase & (command == CMD_REPLAY);

    ipr_ram
    #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    )
    u_line_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (column_reg),
        .wdata (pixel),
        .re    (ram_re),
        .raddr (column_reg),
        .rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_W'(1);
            in_width_reg  <= WIDTH_W'(1);
            in_height_reg <= HEIGHT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                REG_IN_WIDTH:  in_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IN_HEIGHT: in_height_reg <= cfg_data[HEIGHT_W-1:0];
                default:       ;
            endcase
        end
    end

    // counters advance on every accepted item that fits the phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            row_copy_reg   <= '0;
            source_row_reg <= '0;
        end
        else if (accept && !bad_phase)
        begin
            column_reg     <= column_next;
            row_copy_reg   <= row_copy_next;
            source_row_reg <= source_row_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg       <= bad_phase ? '0 : pixel;
            use_ram_reg   <= ~bad_phase & (command == CMD_REPLAY);
            repeat_reg    <= bad_phase ? '0 : eff_scale;
            pad_reg       <= (bad_phase || !rend) ? '0 : pad_calc;
            row_end_reg   <= ~bad_phase & rend;
            image_end_reg <= ~bad_phase & iend;
            err_reg       <= bad_phase;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pixel   = use_ram_reg ? ram_rdata : pix_reg;
    assign repeat_res  = repeat_reg;
    assign pad_bytes   = pad_reg;
    assign row_end     = row_end_reg;
    assign image_end   = image_end_reg;
    assign phase_error = err_reg;

endmodule

FILE: sv/ipr_checker.sv
// ----------------------------------------------------------------------------
// ipr_assertions
// Port-level checks for the integer pixel replication scaler.
// ----------------------------------------------------------------------------
module ipr_assertions
    import ipr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 command,
    input  logic [PIX_W-1:0]     pixel,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [PIX_W-1:0]     out_pixel,
    input  logic [SCALE_W-1:0]   repeat_res,
    input  logic [PAD_W-1:0]     pad_bytes,
    input  logic                 row_end,
    input  logic                 image_end,
    input  logic                 phase_error
);

    // a flagged command carries no pixel information
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase_error) |->
            (out_pixel == '0 && repeat_res == '0 && pad_bytes == '0 &&
             row_end == 1'b0 && image_end == 1'b0))
        else $error("phase error result carries data");

    // a good result repeats between one and the scale limit
    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !phase_error) |->
            (repeat_res != '0 && repeat_res <= SCALE_W'(SCALE_LIMIT)))
        else $error("repeat count out of range");

    // image end and padding occur only on the last pixel of a row
    a_end_on_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (image_end || pad_bytes != '0)) |-> row_end)
        else $error("image end or padding away from row end");

    // input is accepted only when the output can move
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output is stalled");

    // a stalled result stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_pixel)))
        else $error("stalled result dropped or changed");

endmodule

bind integer_pixel_replication_scaler ipr_assertions u_ipr_assertions (.*);
